FILE: design/drw_pkg.sv
// drw_pkg: shared types, codes and helper functions for the drive ramp watchdog controller
// used by every module of the block; depends on nothing
package drw_pkg;

  localparam int DutyW  = 8;
  localparam int StateW = 2;
  localparam int RampW  = 16;
  localparam int PktW   = 17;
  localparam int CfgIdxW = 2;

  // opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_CMD   = 2'd1;
  localparam logic [1:0] OP_SPEED = 2'd2;

  // drive states
  localparam logic [StateW-1:0] ST_IDLE = 2'd0;
  localparam logic [StateW-1:0] ST_FWD  = 2'd1;
  localparam logic [StateW-1:0] ST_BACK = 2'd2;

  // command bytes
  localparam logic [7:0] CMD_FWD  = 8'h57;
  localparam logic [7:0] CMD_BACK = 8'h53;
  localparam logic [7:0] CMD_STOP = 8'h58;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_RAMP_INTERVAL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WDOG_TIMEOUT  = 2'd1;

  localparam logic [RampW-1:0] RAMP_INTERVAL_RST = 16'd20;
  localparam logic [RampW-1:0] WDOG_TIMEOUT_RST  = 16'd1000;
  localparam logic [RampW-1:0] RAMP_MAX = 16'hFFFF;
  localparam logic [PktW-1:0]  PKT_MAX  = 17'h1FFFF;

  localparam logic [DutyW:0] ACCEL_STEP = 9'd2;
  localparam logic [DutyW:0] DECEL_STEP = 9'd4;

  localparam logic [7:0] PCT_MAX = 8'd100;
  // floor(x/100) == (x * 5243) >> 19 for x up to 25500; 255 folded into the constant
  localparam logic [20:0] TGT_MULT = 21'd1336965;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] command_byte;
    logic [7:0] speed_percent;
  } drw_item_t;

  typedef struct packed {
    logic [StateW-1:0] applied;
    logic [DutyW-1:0]  duty_out;
    logic              brake;
    logic              power;
    logic [1:0]        dir;     // bit0 left, bit1 right
  } drw_drive_t;

  typedef struct packed {
    logic [DutyW-1:0]  pwm_duty;
    logic [StateW-1:0] applied_state;
    logic              left_dir;
    logic              right_dir;
    logic              brake_on;
    logic              power_on;
    logic              watchdog_flag;
    logic [DutyW-1:0]  duty_now;
  } drw_result_t;

  // target duty = 255*(100-p)/100 with p saturated at 100
  function automatic logic [DutyW-1:0] target_from_percent(input logic [7:0] pct);
    logic [6:0]  inv;
    logic [27:0] prod;
    logic [7:0]  diff;
    diff = (pct > PCT_MAX) ? 8'd0 : (PCT_MAX - pct);
    inv  = diff[6:0];
    prod = {21'd0, inv} * {7'd0, TGT_MULT};
    return prod[26:19];
  endfunction

  // drive the pins for a state and duty; idle or zero duty keeps dir and power
  function automatic drw_drive_t drive_apply(input logic [StateW-1:0] st,
                                             input logic [DutyW-1:0]  duty,
                                             input drw_drive_t        prev);
    drw_drive_t d;
    d = prev;
    d.applied = st;
    if (st == ST_IDLE || duty == '0) begin
      d.duty_out = '0;
      d.brake    = 1'b1;
    end else begin
      d.power    = 1'b1;
      d.dir      = (st == ST_FWD) ? 2'b01 : 2'b10;
      d.brake    = 1'b0;
      d.duty_out = duty;
    end
    return d;
  endfunction

endpackage

FILE: design/drw_in_reg.sv
// drw_in_reg: input register stage holding one accepted transaction
// depends on drw_pkg
module drw_in_reg
  import drw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  drw_item_t in_item,
  input  logic      advance,
  output logic      item_valid,
  output drw_item_t item
);

  logic      valid_r, valid_nxt;
  drw_item_t item_r;
  logic      take;

  assign in_stall  = valid_r & ~advance;
  assign take      = in_valid & ~in_stall;
  assign valid_nxt = take | (valid_r & ~advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: design/drw_core.sv
// drw_core: configuration registers, drive state and the per-transaction update
// depends on drw_pkg
module drw_core
  import drw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [RampW-1:0]   cfg_wdata,
  input  logic               fire,
  input  drw_item_t          item,
  output drw_result_t        result
);

  logic [RampW-1:0]  ramp_interval_r, wdog_timeout_r;
  logic [DutyW-1:0]  cur_r, cur_nxt;
  logic [DutyW-1:0]  tgt_r, tgt_nxt;
  logic [StateW-1:0] cmd_r, cmd_nxt;
  logic [RampW-1:0]  ramp_r, ramp_nxt;
  logic [PktW-1:0]   pkt_r, pkt_nxt;
  logic              trip_r, trip_nxt;
  drw_drive_t        drv_r, drv_nxt;

  logic [RampW-1:0]  ramp_inc;
  logic [PktW-1:0]   pkt_inc;
  logic [DutyW:0]    up_sum, dn_lim;
  logic [DutyW-1:0]  cur_step;

  assign ramp_inc = (ramp_r == RAMP_MAX) ? ramp_r : ramp_r + 16'd1;
  assign pkt_inc  = (pkt_r == PKT_MAX) ? pkt_r : pkt_r + 17'd1;
  assign up_sum   = {1'b0, cur_r} + ACCEL_STEP;
  assign dn_lim   = {1'b0, tgt_r} + DECEL_STEP;

  // one ramp step toward target, clamped so it never passes it
  always_comb begin
    cur_step = cur_r;
    if (cur_r < tgt_r) begin
      cur_step = (up_sum > {1'b0, tgt_r}) ? tgt_r : up_sum[DutyW-1:0];
    end else if (cur_r > tgt_r) begin
      cur_step = ({1'b0, cur_r} < dn_lim) ? tgt_r : cur_r - 8'd4;
    end
  end

  always_comb begin
    cur_nxt  = cur_r;
    tgt_nxt  = tgt_r;
    cmd_nxt  = cmd_r;
    ramp_nxt = ramp_r;
    pkt_nxt  = pkt_r;
    trip_nxt = trip_r;
    drv_nxt  = drv_r;
    if (fire) begin
      unique case (item.opcode)
        OP_TICK: begin
          if (ramp_inc >= ramp_interval_r) begin
            cur_nxt  = cur_step;
            ramp_nxt = '0;
            drv_nxt  = drive_apply(cmd_r, cur_step, drv_r);
          end else begin
            ramp_nxt = ramp_inc;
          end
          pkt_nxt = pkt_inc;
          if (!trip_r && pkt_inc > {1'b0, wdog_timeout_r}) begin
            tgt_nxt  = '0;
            cur_nxt  = '0;
            drv_nxt  = drive_apply(ST_IDLE, '0, drv_nxt);
            trip_nxt = 1'b1;
          end
        end
        OP_CMD: begin
          pkt_nxt  = '0;
          trip_nxt = 1'b0;
          priority if (item.command_byte == CMD_FWD) begin
            cmd_nxt = ST_FWD;
          end else if (item.command_byte == CMD_BACK) begin
            cmd_nxt = ST_BACK;
          end else if (item.command_byte == CMD_STOP) begin
            tgt_nxt = '0;
            cur_nxt = '0;
            drv_nxt = drive_apply(ST_IDLE, '0, drv_r);
          end else begin
            cmd_nxt = cmd_r;
          end
        end
        OP_SPEED: begin
          tgt_nxt = target_from_percent(item.speed_percent);
        end
        default: begin
          cur_nxt = cur_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_interval_r <= RAMP_INTERVAL_RST;
      wdog_timeout_r  <= WDOG_TIMEOUT_RST;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_RAMP_INTERVAL) begin
        ramp_interval_r <= cfg_wdata;
      end
      if (cfg_idx == CFG_WDOG_TIMEOUT) begin
        wdog_timeout_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r          <= '0;
      tgt_r          <= '0;
      cmd_r          <= ST_IDLE;
      ramp_r         <= '0;
      pkt_r          <= '0;
      trip_r         <= 1'b0;
      drv_r.applied  <= ST_IDLE;
      drv_r.duty_out <= '0;
      drv_r.brake    <= 1'b1;
      drv_r.power    <= 1'b0;
      drv_r.dir      <= 2'b00;
    end else begin
      cur_r  <= cur_nxt;
      tgt_r  <= tgt_nxt;
      cmd_r  <= cmd_nxt;
      ramp_r <= ramp_nxt;
      pkt_r  <= pkt_nxt;
      trip_r <= trip_nxt;
      drv_r  <= drv_nxt;
    end
  end

  // result reflects the state after this transaction
  always_comb begin
    result.pwm_duty      = drv_nxt.duty_out;
    result.applied_state = drv_nxt.applied;
    result.left_dir      = drv_nxt.dir[0];
    result.right_dir     = drv_nxt.dir[1];
    result.brake_on      = drv_nxt.brake;
    result.power_on      = drv_nxt.power;
    result.watchdog_flag = trip_nxt;
    result.duty_now      = cur_nxt;
  end

endmodule

FILE: design/drw_out_reg.sv
// drw_out_reg: result register toward the output channel
// depends on drw_pkg
module drw_out_reg
  import drw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  drw_result_t result,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_stall,
  output drw_result_t out_result
);

  logic        valid_r, valid_nxt;
  drw_result_t result_r;

  assign advance   = item_valid & (~valid_r | ~out_stall);
  assign valid_nxt = advance | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

FILE: design/drive_ramp_watchdog_controller_unit.sv
// drive_ramp_watchdog_controller_unit: top level of the drive ramp and watchdog controller
// depends on drw_pkg, drw_in_reg, drw_core, drw_out_reg
//
// One transaction (a millisecond tick, a command byte or a speed update) is accepted every
// clock cycle while in_stall is low. It is held in the input register, and its result is
// loaded into the result register, which drives out_valid, once that register is empty or
// its result is taken. While a result waits under out_stall one more transaction can enter
// the input register; after that in_stall stays high until the waiting result is taken.
// The state update for a transaction is a single pass of compare, increment and clamp logic,
// so the sustained rate is one transaction per cycle while out_stall is low. Configuration
// writes (index 0 ramp interval, index 1 watchdog timeout, other indexes ignored) are always
// ready and take effect on the next cycle.
module drive_ramp_watchdog_controller_unit
  import drw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_command_byte,
  input  logic [7:0]         in_speed_percent,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DutyW-1:0]   out_pwm_duty,
  output logic [StateW-1:0]  out_applied_state,
  output logic               out_left_dir,
  output logic               out_right_dir,
  output logic               out_brake_on,
  output logic               out_power_on,
  output logic               out_watchdog_flag,
  output logic [DutyW-1:0]   out_duty_now,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [RampW-1:0]   cfg_data
);

  drw_item_t   in_item, item;
  drw_result_t result, out_result;
  logic        item_valid, advance;

  assign in_item.opcode        = in_opcode;
  assign in_item.command_byte  = in_command_byte;
  assign in_item.speed_percent = in_speed_percent;
  assign cfg_ready             = 1'b1;

  drw_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  drw_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .fire      (advance),
    .item      (item),
    .result    (result)
  );

  drw_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_pwm_duty      = out_result.pwm_duty;
  assign out_applied_state = out_result.applied_state;
  assign out_left_dir      = out_result.left_dir;
  assign out_right_dir     = out_result.right_dir;
  assign out_brake_on      = out_result.brake_on;
  assign out_power_on      = out_result.power_on;
  assign out_watchdog_flag = out_result.watchdog_flag;
  assign out_duty_now      = out_result.duty_now;

endmodule

FILE: design/drw_checker.sv
// drw_checker: port-level checks on the drive ramp watchdog controller, bound to the top level
// depends on drw_pkg and drive_ramp_watchdog_controller_unit
module drw_checker
  import drw_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [DutyW-1:0]   out_pwm_duty,
  input logic [StateW-1:0]  out_applied_state,
  input logic               out_left_dir,
  input logic               out_right_dir,
  input logic               out_brake_on,
  input logic               out_power_on
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pwm_duty))
    else $error("stalled transaction changed");

  // brakes on exactly when no duty is driven
  a_brake_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_brake_on == (out_pwm_duty == '0)))
    else $error("brake and pwm duty disagree");

  // released brakes mean power on with exactly one direction
  a_drive_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_brake_on |->
      out_power_on && (out_left_dir != out_right_dir) && (out_applied_state != ST_IDLE))
    else $error("drive pins inconsistent with released brakes");

  a_idle_brakes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_applied_state == ST_IDLE |-> out_brake_on)
    else $error("idle state without brakes");

endmodule

bind drive_ramp_watchdog_controller_unit drw_checker u_drw_checker (.*);
